@@ sv/mm64_pkg.sv @@
// Shared types and register codes for the 64-bit Montgomery multiplier.
// Used by mm64_mul and montgomery_multiply_64; depends on nothing else.
package mm64_pkg;

  // Operand and product word types.
  typedef logic [31:0]  half_t;
  typedef logic [63:0]  word_t;
  typedef logic [127:0] dword_t;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODULUS     = 1'b0,
    REG_NEG_INVERSE = 1'b1
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam word_t ModulusReset    = 64'd1;
  localparam word_t NegInverseReset = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

@@ sv/mm64_mul.sv @@
// Two-stage pipelined 64x64 -> 128-bit unsigned multiplier.
// Stage one forms four 32x32 partial products, stage two combines them.
// Depends on mm64_pkg for the word types.
module mm64_mul (
  input  logic             clk_i,
  input  mm64_pkg::word_t  x_i,
  input  mm64_pkg::word_t  y_i,
  output mm64_pkg::dword_t p_o
);

  mm64_pkg::word_t  pp00_q, pp01_q, pp10_q, pp11_q;
  mm64_pkg::dword_t p_d, p_q;
  logic [33:0]      mid;

  // Partial products of the 32-bit halves.
  always_ff @(posedge clk_i) begin
    pp00_q <= 64'(x_i[31:0])  * 64'(y_i[31:0]);
    pp01_q <= 64'(x_i[31:0])  * 64'(y_i[63:32]);
    pp10_q <= 64'(x_i[63:32]) * 64'(y_i[31:0]);
    pp11_q <= 64'(x_i[63:32]) * 64'(y_i[63:32]);
  end

  // Middle column sum, then the upper half with its carries.
  always_comb begin
    mid = 34'(pp00_q[63:32]) + 34'(pp10_q[31:0]) + 34'(pp01_q[31:0]);
    p_d = {pp11_q + 64'(pp10_q[63:32]) + 64'(pp01_q[63:32]) + 64'(mid[33:32]),
           mid[31:0], pp00_q[31:0]};
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ sv/montgomery_multiply_64.sv @@
// Top level of the 64-bit Montgomery multiplier, radix 2^64.
// Depends on mm64_pkg and instantiates mm64_mul twice.
//
// Usage:
//   An item (operand_a_i, operand_b_i) is taken at a rising edge where start
//   is high and busy is low. busy never rises: the pipeline takes one item
//   in every cycle. The result appears on product_o with done_o high for
//   exactly one cycle, in the order the items were taken. The receiver cannot
//   hold results off. Throughput is one item per cycle; the pipeline runs
//   through the operand capture register, the two 64x64 multipliers (two
//   stages each), the two-stage low-half product for the reduction factor,
//   the 129-bit sum stage and the final subtract stage.
//   The modulus and its negated inverse are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while no item is in flight; index 0 is the
//   modulus, index 1 the negated inverse.
//   Reset clears every in-flight item, sets the modulus to one and the
//   negated inverse to all ones.
module montgomery_multiply_64 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [63:0]     operand_a_i,
  input  logic [63:0]     operand_b_i,
  output logic            done_o,
  output logic [63:0]     product_o,
  input  logic            cfg_we_i,
  input  logic [mm64_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]     cfg_data_i
);

  localparam int unsigned Depth = 9;

  mm64_pkg::word_t  modulus_q, ninv_q;
  mm64_pkg::word_t  a_q, b_q;
  mm64_pkg::dword_t t_full, qm_full;
  mm64_pkg::dword_t t3_q, t4_q, t5_q, t6_q;
  mm64_pkg::word_t  l00_q;
  mm64_pkg::half_t  l01_q, l10_q;
  logic [63:0]      l01_full, l10_full;
  mm64_pkg::word_t  q_q;
  logic [128:0]     sum;
  mm64_pkg::word_t  sh_q;
  logic             sc_q;
  mm64_pkg::word_t  prod_d, prod_q;
  logic [Depth-1:0] vld_d, vld_q;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mm64_pkg::ModulusReset;
      ninv_q    <= mm64_pkg::NegInverseReset;
    end else if (cfg_we_i) begin
      unique case (mm64_pkg::cfg_reg_e'(cfg_idx_i))
        mm64_pkg::REG_MODULUS:     modulus_q <= cfg_data_i;
        mm64_pkg::REG_NEG_INVERSE: ninv_q    <= cfg_data_i;
        default:                   modulus_q <= modulus_q;
      endcase
    end
  end

  // Valid bits travel alongside the data stages.
  assign vld_d = {vld_q[Depth-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Operand capture.
  always_ff @(posedge clk_i) begin
    a_q <= operand_a_i;
    b_q <= operand_b_i;
  end

  // Full product t = a * b.
  mm64_mul u_mul_ab (
    .clk_i (clk_i),
    .x_i   (a_q),
    .y_i   (b_q),
    .p_o   (t_full)
  );

  // Low-half products for q = t_low * neg_inverse mod 2^64.
  assign l01_full = 64'(t_full[31:0])  * 64'(ninv_q[63:32]);
  assign l10_full = 64'(t_full[63:32]) * 64'(ninv_q[31:0]);

  always_ff @(posedge clk_i) begin
    l00_q <= 64'(t_full[31:0]) * 64'(ninv_q[31:0]);
    l01_q <= l01_full[31:0];
    l10_q <= l10_full[31:0];
    t3_q  <= t_full;
  end

  // Combine into the reduction factor q.
  always_ff @(posedge clk_i) begin
    q_q  <= l00_q + {l01_q + l10_q, 32'd0};
    t4_q <= t3_q;
  end

  // Full product q * modulus; t waits alongside.
  mm64_mul u_mul_qm (
    .clk_i (clk_i),
    .x_i   (q_q),
    .y_i   (modulus_q),
    .p_o   (qm_full)
  );

  always_ff @(posedge clk_i) begin
    t5_q <= t4_q;
    t6_q <= t5_q;
  end

  // 129-bit sum; only its upper half and carry are kept.
  assign sum = {1'b0, t6_q} + {1'b0, qm_full};

  always_ff @(posedge clk_i) begin
    sh_q <= sum[127:64];
    sc_q <= sum[128];
  end

  // Final conditional subtraction of the modulus.
  assign prod_d = (sc_q || (sh_q >= modulus_q)) ? sh_q - modulus_q : sh_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign product_o = prod_q;
  assign done_o    = vld_q[Depth-1];

`ifndef ASSERT_OFF
  // Every result strobe traces back to an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[0], Depth-1))
    else $error("result strobe without a matching accepted item");

  // With a consistent configuration the low half of the sum cancels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && ((modulus_q * ninv_q) == 64'hFFFF_FFFF_FFFF_FFFF))
      |-> ((t6_q[63:0] + qm_full[63:0]) == 64'd0))
    else $error("low half of the Montgomery sum is not zero");

  // No item is ever refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> vld_q[0])
    else $error("start was not taken into the pipeline");
`endif

endmodule

@@ sim/montgomery_multiply_64_tb.sv @@
// Self-checking testbench for montgomery_multiply_64, the radix 2^64 Montgomery multiplier.
// Depends on mm64_pkg and on the montgomery_multiply_64 RTL; it predicts every product
// on its own and steps through several modulus settings and sender idle rates.
module montgomery_multiply_64_tb;

  localparam int ItemsPerPhase = 206;
  localparam int NumPhases     = 9;
  localparam int DrainCycles   = 12;
  localparam int CycleLimit    = 200000;
  localparam int MaxReports    = 10;
  localparam mm64_pkg::word_t AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    mm64_pkg::word_t a;
    mm64_pkg::word_t b;
  } operand_pair_t;

  // Signals to and from the block. Every input has a known value from time zero.
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  mm64_pkg::word_t operand_a_i = '0;
  mm64_pkg::word_t operand_b_i = '0;
  logic            done_o;
  mm64_pkg::word_t product_o;
  logic            cfg_we_i    = 1'b0;
  logic [mm64_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  mm64_pkg::word_t cfg_data_i  = '0;

  // Testbench copy of the configuration registers.
  mm64_pkg::word_t modulus_r = mm64_pkg::ModulusReset;
  mm64_pkg::word_t neg_inv_r = mm64_pkg::NegInverseReset;

  operand_pair_t   operand_q[$];
  operand_pair_t   next_pair;
  mm64_pkg::word_t product_q[$];
  mm64_pkg::word_t expected_product;
  int              sender_idle_pct = 0;
  int              items_taken     = 0;
  int              products_checked = 0;
  int              fail_count      = 0;
  int              cycle_count     = 0;
  int              settings_used   = 1;

  montgomery_multiply_64 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .product_o   (product_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Montgomery product as the block defines it: t = a*b, q = t*ninv mod 2^64,
  // s = t + q*m over 129 bits, u = s >> 64, and one conditional subtraction of m.
  function automatic mm64_pkg::word_t mont_product(mm64_pkg::word_t a, mm64_pkg::word_t b,
                                                   mm64_pkg::word_t m, mm64_pkg::word_t ninv);
    mm64_pkg::dword_t t;
    mm64_pkg::word_t  q;
    logic [128:0]     s;
    mm64_pkg::word_t  u;
    t = {64'd0, a} * {64'd0, b};
    q = t[63:0] * ninv;
    s = {1'b0, t} + {65'd0, q} * {65'd0, m};
    u = s[127:64];
    if (s[128] || u >= m) begin
      u = u - m;
    end
    return u;
  endfunction

  // Negated inverse of an odd modulus mod 2^64 by Newton iteration.
  function automatic mm64_pkg::word_t neg_inverse_of(mm64_pkg::word_t m);
    mm64_pkg::word_t x;
    x = m;
    repeat (6) begin
      x = x * (64'd2 - m * x);
    end
    return -x;
  endfunction

  function automatic mm64_pkg::word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly operands below the modulus, with corner values and full-range noise.
  function automatic mm64_pkg::word_t rand_operand(mm64_pkg::word_t m);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return '0;
      1: return m - 64'd1;
      2: return AllOnes;
      3: return 64'd1;
      4, 5, 6: return rand_word();
      default: begin
        if (m == '0) begin
          return rand_word();
        end
        return rand_word() % m;
      end
    endcase
  endfunction

  function automatic void push_item(mm64_pkg::word_t a, mm64_pkg::word_t b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    operand_q.push_back(p);
  endfunction

  function automatic void report_failure(string what, mm64_pkg::word_t exp_val,
                                         mm64_pkg::word_t act_val);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("ERROR %s: expected %h, got %h (item %0d)", what, exp_val, act_val,
               products_checked);
    end
  endfunction

  // Both registers are written on back-to-back edges while no item is in flight.
  task automatic write_config(mm64_pkg::word_t m, mm64_pkg::word_t ninv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mm64_pkg::REG_MODULUS;
    cfg_data_i <= m;
    @(posedge clk_i);
    modulus_r  = m;
    cfg_idx_i  <= mm64_pkg::REG_NEG_INVERSE;
    cfg_data_i <= ninv;
    @(posedge clk_i);
    neg_inv_r  = ninv;
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (operand_q.size() != 0 || start || product_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: records the expected product of each accepted item, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        product_q.push_back(mont_product(operand_a_i, operand_b_i, modulus_r, neg_inv_r));
        items_taken++;
      end
      if (!(start && busy)) begin
        if (operand_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_pair = operand_q.pop_front();
          start       <= 1'b1;
          operand_a_i <= next_pair.a;
          operand_b_i <= next_pair.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed product is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (product_q.size() == 0) begin
        report_failure("product with no item pending", '0, product_o);
      end else begin
        expected_product = product_q.pop_front();
        if (product_o !== expected_product) begin
          report_failure("product mismatch", expected_product, product_o);
        end
        products_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus: one register setting per phase, rotating through the idle rates.
  initial begin
    int              idle_rates[4];
    mm64_pkg::word_t m;
    mm64_pkg::word_t ninv;
    idle_rates = '{0, 56, 0, 31};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Choose the setting: extremes, zero and even moduli, wrong inverses, typical ones.
      m    = mm64_pkg::ModulusReset;
      ninv = mm64_pkg::NegInverseReset;
      case (ph)
        1: begin
          m    = AllOnes;
          ninv = 64'd1;
        end
        2: begin
          m    = rand_word() | 64'd1;
          ninv = neg_inverse_of(m);
        end
        3: begin
          m    = '0;
          ninv = rand_word();
        end
        4: begin
          m    = rand_word() & ~64'd1;
          ninv = rand_word();
        end
        5: begin
          m    = rand_word() | 64'h8000_0000_0000_0001;
          ninv = neg_inverse_of(m);
        end
        6: begin
          m    = 64'd1;
          ninv = '0;
        end
        7: begin
          m    = 64'($urandom_range(1, 65535)) | 64'd1;
          ninv = neg_inverse_of(m);
        end
        8: begin
          m    = rand_word() | 64'd1;
          ninv = neg_inverse_of(m) ^ 64'($urandom_range(0, 1) << 5);
        end
        default: ;
      endcase
      if (ph != 0) begin
        write_config(m, ninv);
      end
      sender_idle_pct = idle_rates[ph % 4];

      // Corner operands with the largest modulus.
      if (ph == 1) begin
        push_item('0, '0);
        push_item('0, AllOnes);
        push_item(AllOnes, '0);
        push_item(AllOnes, AllOnes);
        push_item(64'd1, 64'd1);
        push_item(m - 64'd1, m - 64'd1);
        push_item(m - 64'd1, 64'd1);
        push_item(64'd1, m - 64'd1);
        push_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        push_item(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        push_item(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000);
        push_item(64'd1, 64'h0000_0000_FFFF_FFFF);
      end

      for (int i = 0; i < ItemsPerPhase; i++) begin
        push_item(rand_operand(m), rand_operand(m));
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (product_q.size() != 0) begin
      report_failure("products never delivered", 64'(product_q.size()), '0);
    end

    $display("Checked %0d products from %0d items over %0d register settings.",
             products_checked, items_taken, settings_used);
    $display("Settings included zero, even and largest moduli; %0d failures.", fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
